// File: rtl/ppt_pkg.sv
// Shared types and constants for the pointer position tracker.
// Used by the front, queue, back and top-level modules; no dependencies.

package ppt_pkg;

  // Default fixed-point format of the cursor accumulators.
  localparam int POS_INT_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF    = 8;

  // Fraction bits carried by the speed register (Q4.8).
  localparam int SPEED_FRAC = 8;

  // Widths fixed by the channel fields.
  localparam int DELTA_W   = 9;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int POS_OUT_W = 20;
  localparam int BTN_N     = 3;
  localparam int BTN_IDX_W = 2;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 48;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] MAX_ROW_RST = 12'd24;
  localparam logic [CFG_W-1:0] MAX_COL_RST = 12'd79;
  localparam logic [CFG_W-1:0] SPEED_RST   = 12'd256;
  localparam logic             ENABLED_RST = 1'b1;

  // Result kinds.
  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  // Button codes.
  localparam logic [BTN_IDX_W-1:0] BTN_LEFT   = 2'd0;
  localparam logic [BTN_IDX_W-1:0] BTN_MIDDLE = 2'd1;
  localparam logic [BTN_IDX_W-1:0] BTN_RIGHT  = 2'd2;

  // One classified report, as handed from front to back.
  typedef struct packed {
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic [BTN_N-1:0]     changed;
    logic [BTN_N-1:0]     now;
  } report_t;

  // Handshake between a producer and a consumer of reports.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

// File: rtl/ppt_front.sv
// Front end of the pointer position tracker: accepts reports, scales the
// motion, updates the clamped cursor accumulators and pushes classified reports.
// Depends on ppt_pkg.

module ppt_front #(
  parameter int POS_INT_BITS = ppt_pkg::POS_INT_BITS_DEF,
  parameter int FRAC_BITS    = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ppt_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [ppt_pkg::CFG_W-1:0]     max_row,
  input  logic [ppt_pkg::CFG_W-1:0]     max_col,
  input  logic [ppt_pkg::CFG_W-1:0]     speed,
  input  logic                          enabled,
  output logic                          push_valid,
  input  logic                          push_ready,
  output ppt_pkg::report_t              push_entry
);

  localparam int POS_W = POS_INT_BITS + FRAC_BITS;
  localparam int PW    = ppt_pkg::DELTA_W + ppt_pkg::CFG_W + 1;
  localparam int SHL   = (FRAC_BITS >= ppt_pkg::SPEED_FRAC) ?
                         FRAC_BITS - ppt_pkg::SPEED_FRAC : 0;
  localparam int SHR   = (FRAC_BITS < ppt_pkg::SPEED_FRAC) ?
                         ppt_pkg::SPEED_FRAC - FRAC_BITS : 0;
  localparam int DW    = PW + SHL;
  localparam int SW    = ((POS_W > DW) ? POS_W : DW) + 2;

  // Stage 1: products and button levels.
  logic                          s1_valid;
  logic signed [PW-1:0]          prod_x;
  logic signed [PW-1:0]          prod_y;
  logic [ppt_pkg::BTN_N-1:0]     s1_btn;
  logic                          s1_adv;

  // Stage 2: accumulators and button memory.
  logic [POS_W-1:0]              row_acc;
  logic [POS_W-1:0]              col_acc;
  logic [ppt_pkg::BTN_N-1:0]     prev_buttons;
  logic [POS_W-1:0]              row_acc_next;
  logic [POS_W-1:0]              col_acc_next;

  logic signed [ppt_pkg::DELTA_W-1:0] dx_in;
  logic signed [ppt_pkg::DELTA_W-1:0] dy_in;
  logic signed [ppt_pkg::CFG_W:0]     speed_s;

  logic signed [DW-1:0]          dx_scaled;
  logic signed [DW-1:0]          dy_scaled;
  logic signed [SW-1:0]          row_sum;
  logic signed [SW-1:0]          col_sum;
  logic [SW-1:0]                 full_lim;
  logic [SW-1:0]                 row_lim_raw;
  logic [SW-1:0]                 col_lim_raw;
  logic signed [SW-1:0]          row_lim;
  logic signed [SW-1:0]          col_lim;
  logic [POS_W+ppt_pkg::POS_OUT_W-1:0] row_ext;
  logic [POS_W+ppt_pkg::POS_OUT_W-1:0] col_ext;

  assign dx_in   = s_tdata[8:0];
  assign dy_in   = s_tdata[17:9];
  assign speed_s = $signed({1'b0, speed});

  assign s1_adv     = s1_valid && (push_ready || !enabled);
  assign s_tready   = !s1_valid || s1_adv;
  assign push_valid = s1_valid && enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      prod_x <= PW'(dx_in) * PW'(speed_s);
      prod_y <= PW'(dy_in) * PW'(speed_s);
      s1_btn <= s_tdata[20:18];
    end
  end

  // Rescale to the accumulator format; the right shift floors negative values.
  always_comb begin
    dx_scaled = (DW'(prod_x) <<< SHL) >>> SHR;
    dy_scaled = (DW'(prod_y) <<< SHL) >>> SHR;
  end

  always_comb begin
    full_lim    = SW'({POS_W{1'b1}});
    row_lim_raw = SW'(max_row) << FRAC_BITS;
    col_lim_raw = SW'(max_col) << FRAC_BITS;
    row_lim     = $signed((row_lim_raw > full_lim) ? full_lim : row_lim_raw);
    col_lim     = $signed((col_lim_raw > full_lim) ? full_lim : col_lim_raw);

    row_sum = $signed(SW'(row_acc)) - SW'(dy_scaled);
    col_sum = $signed(SW'(col_acc)) + SW'(dx_scaled);

    if (row_sum < 0) begin
      row_acc_next = '0;
    end else if (row_sum > row_lim) begin
      row_acc_next = row_lim[POS_W-1:0];
    end else begin
      row_acc_next = row_sum[POS_W-1:0];
    end

    if (col_sum < 0) begin
      col_acc_next = '0;
    end else if (col_sum > col_lim) begin
      col_acc_next = col_lim[POS_W-1:0];
    end else begin
      col_acc_next = col_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc      <= '0;
      col_acc      <= '0;
      prev_buttons <= '0;
    end else if (s1_adv) begin
      row_acc      <= row_acc_next;
      col_acc      <= col_acc_next;
      prev_buttons <= s1_btn;
    end
  end

  // The result fields carry the low 20 bits of the position.
  always_comb begin
    row_ext = (POS_W + ppt_pkg::POS_OUT_W)'(row_acc_next);
    col_ext = (POS_W + ppt_pkg::POS_OUT_W)'(col_acc_next);
    push_entry.row     = row_ext[ppt_pkg::POS_OUT_W-1:0];
    push_entry.col     = col_ext[ppt_pkg::POS_OUT_W-1:0];
    push_entry.changed = s1_btn ^ prev_buttons;
    push_entry.now     = s1_btn;
  end

endmodule

// File: rtl/ppt_queue.sv
// Short report queue between the front and back of the pointer tracker.
// Register-based FIFO of ppt_pkg::report_t entries; depends on ppt_pkg.

module ppt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ppt_pkg::report_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ppt_pkg::report_t pop_entry
);

  localparam int DEPTH = ppt_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ppt_pkg::report_t  slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  ppt_pkg::link_t    wr;
  ppt_pkg::link_t    rd;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];

  assign wr.valid = push_valid;
  assign wr.ready = push_ready;
  assign rd.valid = pop_valid;
  assign rd.ready = pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid && wr.ready) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd.valid && rd.ready) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((wr.valid && wr.ready) && !(rd.valid && rd.ready)) begin
        count <= count + 1'b1;
      end else if (!(wr.valid && wr.ready) && (rd.valid && rd.ready)) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid && wr.ready) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: rtl/ppt_back.sv
// Back end of the pointer tracker: expands each queued report into a move
// result and one result per changed button, into an output register.
// Depends on ppt_pkg.

module ppt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  ppt_pkg::report_t              pop_entry,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ppt_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  ppt_pkg::report_t              cur;
  logic                          cur_valid;
  logic                          move_sent;
  logic [ppt_pkg::BTN_N-1:0]     pending;

  logic                          out_free;
  logic                          advance;
  logic                          res_kind;
  logic [ppt_pkg::BTN_IDX_W-1:0] res_btn;
  logic                          res_pressed;
  logic                          res_last;
  logic [ppt_pkg::BTN_N-1:0]     pick;
  logic [ppt_pkg::BTN_N-1:0]     pending_next;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = cur_valid && out_free;
  assign pop_ready = !cur_valid || (advance && res_last);

  // Next result of the current report: the move first, then the lowest
  // changed button that is still pending.
  always_comb begin
    pick = '0;
    if (pending[0]) begin
      pick    = 3'b001;
      res_btn = ppt_pkg::BTN_LEFT;
    end else if (pending[1]) begin
      pick    = 3'b010;
      res_btn = ppt_pkg::BTN_MIDDLE;
    end else begin
      pick    = 3'b100;
      res_btn = ppt_pkg::BTN_RIGHT;
    end

    if (!move_sent) begin
      res_kind     = ppt_pkg::KIND_MOVE;
      res_btn      = ppt_pkg::BTN_LEFT;
      res_pressed  = 1'b0;
      pending_next = pending;
      res_last     = (pending == '0);
    end else begin
      res_kind     = ppt_pkg::KIND_BUTTON;
      res_pressed  = |(cur.now & pick);
      pending_next = pending & ~pick;
      res_last     = (pending_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      move_sent <= 1'b0;
      pending   <= '0;
    end else if (pop_valid && pop_ready) begin
      cur_valid <= 1'b1;
      move_sent <= 1'b0;
      pending   <= pop_entry.changed;
    end else if (advance) begin
      cur_valid <= !res_last;
      move_sent <= 1'b1;
      pending   <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, res_pressed, res_btn, cur.col, cur.row};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

// File: rtl/pointer_position_tracker.sv
// Top level of the pointer position tracker: configuration registers, front
// end, report queue and back end. Depends on ppt_pkg, ppt_front, ppt_queue
// and ppt_back.
//
// Usage: each mouse report enters on the s_ stream (dx, dy, three button
// levels). The cursor row and column live in unsigned fixed point and are
// moved by dx and -dy times speed, clamped to zero and the configured maxima.
// While enabled, each report yields a move result on the m_ stream (tuser 0)
// and then one button result (tuser 1) per changed button, left to right;
// tlast marks the final result of the report. Disabled reports still move the
// cursor and update the button memory but produce nothing.
// Path: the first result of a report passes the multiply register, a queue
// slot, the back end's report register and the output register. Throughput:
// one report per cycle enters while the queue has room; the output register
// gives one result per cycle while the receiver takes them, so a report with
// k button changes yields 1 + k results (up to four). The front end holds a
// multiply stage and an accumulator stage.
// When the receiver stalls, results wait in the output register and reports
// wait in the four-entry queue; once it fills, s_tready drops.
// Reset clears the cursor to the origin, releases all buttons, empties the
// queue and loads the register defaults (max row 24, max col 79, speed 1.0,
// enabled).

module pointer_position_tracker #(
  parameter int POS_INT_BITS = ppt_pkg::POS_INT_BITS_DEF,
  parameter int FRAC_BITS    = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // dx[8:0], dy[17:9], left_down[18], middle_down[19], right_down[20], zeros
  input  logic [ppt_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // row_pos[19:0], col_pos[39:20], button[41:40], pressed[42], zeros
  output logic [ppt_pkg::M_DATA_W-1:0]   m_tdata,
  // kind[0]
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppt_pkg::CFG_W-1:0]      cfg_data
);

  logic [ppt_pkg::CFG_W-1:0] max_row;
  logic [ppt_pkg::CFG_W-1:0] max_col;
  logic [ppt_pkg::CFG_W-1:0] speed;
  logic                      enabled;

  logic             push_valid;
  logic             push_ready;
  ppt_pkg::report_t push_entry;
  logic             pop_valid;
  logic             pop_ready;
  ppt_pkg::report_t pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_row <= ppt_pkg::MAX_ROW_RST;
      max_col <= ppt_pkg::MAX_COL_RST;
      speed   <= ppt_pkg::SPEED_RST;
      enabled <= ppt_pkg::ENABLED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppt_pkg::REG_MAX_ROW: max_row <= cfg_data;
        ppt_pkg::REG_MAX_COL: max_col <= cfg_data;
        ppt_pkg::REG_SPEED:   speed   <= cfg_data;
        ppt_pkg::REG_ENABLED: enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ppt_front #(
    .POS_INT_BITS (POS_INT_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .max_row    (max_row),
    .max_col    (max_col),
    .speed      (speed),
    .enabled    (enabled),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ppt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ppt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A move result carries no button and no pressed level.
  a_move_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ppt_pkg::KIND_MOVE)) |-> (m_tdata[42:40] == 3'b000))
    else $error("move result with button fields set");

  // Button results name only left, middle or right.
  a_button_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ppt_pkg::KIND_BUTTON)) |-> (m_tdata[41:40] != 2'd3))
    else $error("button result with unknown button code");

  // A report's results come back to back, and only button results follow a
  // result that is not the last.
  a_report_burst: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
    (m_tvalid && (m_tuser == ppt_pkg::KIND_BUTTON)))
    else $error("report results interrupted");

endmodule
